// ----- hdl/mscrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mscrc_pkg;

    // operation codes carried in s_tuser
    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [7:0] POLY_RESET = 8'h2F;
    localparam logic [2:0] FRAME_TAIL = 3'b010;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 48;
    localparam int HEAD_W     = 21;

    // one classified item, waiting for the second crc byte step
    typedef struct packed {
        logic              op;
        logic [7:0]        crc_mid;
        logic [7:0]        msg_b1;
        logic [7:0]        msg_b0;
        logic [HEAD_W-1:0] head;
        logic [7:0]        rx_crc;
        logic [7:0]        rx_data;
        logic              mism;
    } fr_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qs_t;

    // eight shifts of x, xor poly after each shift that drops a set top bit
    function automatic logic [7:0] crc_byte_step(input logic [7:0] x, input logic [7:0] poly);
        logic [7:0] c;
        c = x;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ poly;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mscrc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mscrc_front
    import mscrc_pkg::*;
(
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic [7:0]           poly,
    input  wire qs_t                  q_stat,
    output logic                      push,
    output fr_entry_t                 push_entry
);

    logic [4:0]  dev;
    logic [5:0]  regad;
    logic        all_p;
    logic [7:0]  data;
    logic [31:0] rx;
    logic [7:0]  msg_b2;

    assign dev   = s_tdata[4:0];
    assign regad = s_tdata[10:5];
    assign all_p = s_tdata[11];
    assign data  = s_tdata[19:12];
    assign rx    = s_tdata[51:20];

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        push_entry    = '0;
        push_entry.op = s_tuser;
        if (s_tuser == OP_BUILD)
        begin
            // message is frame bits 31..11, bit 11 is zero
            push_entry.head   = {dev, regad, data, all_p, 1'b0};
            msg_b2            = {3'b000, dev};
            push_entry.msg_b1 = {regad, data[7:6]};
            push_entry.msg_b0 = {data[5:0], all_p, 1'b0};
        end
        else
        begin
            // message is received bits 31..10
            msg_b2             = {2'b00, rx[31:26]};
            push_entry.msg_b1  = rx[25:18];
            push_entry.msg_b0  = rx[17:10];
            push_entry.rx_crc  = rx[9:2];
            push_entry.rx_data = rx[20:13];
            push_entry.mism    = (rx[31:27] != dev) || (rx[26:21] != regad);
        end
        push_entry.crc_mid = crc_byte_step(msg_b2, poly);
    end

endmodule

`default_nettype wire

// ----- hdl/mscrc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mscrc_queue
    import mscrc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire fr_entry_t push_entry,
    input  wire logic      pop,
    output fr_entry_t      head_entry,
    output qs_t            stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fr_entry_t       store_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_entry = store_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(DEPTH));

endmodule

`default_nettype wire

// ----- hdl/mscrc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mscrc_back
    import mscrc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [7:0]            poly,
    input  wire qs_t                   q_stat,
    input  wire fr_entry_t             head_entry,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic [7:0]            crc;

    assign pop = !q_stat.empty && (!out_valid_reg || m_tready);

    always_comb
    begin
        crc = crc_byte_step(head_entry.crc_mid ^ head_entry.msg_b1, poly) ^ head_entry.msg_b0;
        out_data_next = '0;
        if (head_entry.op == OP_BUILD)
        begin
            out_data_next[31:0] = {head_entry.head, crc, FRAME_TAIL};
        end
        else
        begin
            out_data_next[39:32] = head_entry.rx_data;
            out_data_next[40]    = (crc != head_entry.rx_crc);
            out_data_next[41]    = head_entry.mism;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- hdl/monitor_spi_frame_crc8_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// builds and checks 32-bit daisy-chain command frames with a programmable crc-8.
// a build item (s_tuser = 0) packs device address, register address, data byte and
// the all-parts bit, appends the msb-first crc-8 over frame bits 31..11 and the tail
// 010. a check item (s_tuser = 1) recomputes the crc over received bits 31..10 and
// compares it with bits 9..2, compares the echoed addresses with the expected ones
// and returns the data byte in bits 20..13. one item is accepted per cycle while
// m_tready is high. the front stage classifies the item and runs the first crc
// byte step, a small queue decouples it from the back stage, which runs the second
// byte step into the output register feeding the master side. the user must write the
// polynomial (reset 0x2f) through cfg_wen / cfg_wdata only while idle (not enforced).

module monitor_spi_frame_crc8_core
    import mscrc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config
    input  wire logic        cfg_wen,
    input  wire logic [7:0]  cfg_wdata,      // crc_polynomial
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [4:0] device_address, [10:5] register_address, [11] all_parts,
    // [19:12] data_byte, [51:20] received_frame, [55:52] zero
    input  wire logic [55:0] s_tdata,
    input  wire logic        s_tuser,        // [0] operation
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] frame_out, [39:32] read_data, [40] crc_error,
    // [41] address_mismatch, [47:42] zero
    output logic [47:0]      m_tdata
);

    logic [7:0] poly_reg;
    logic       push;
    logic       pop;
    fr_entry_t  push_entry;
    fr_entry_t  head_entry;
    qs_t        q_stat;

    // generator polynomial, implicit x^8
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= POLY_RESET;
        end
        else if (cfg_wen)
        begin
            poly_reg <= cfg_wdata;
        end
    end

    // front: accept, classify, first crc byte step
    mscrc_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .poly       (poly_reg),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    // decoupling queue
    mscrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .stat       (q_stat)
    );

    // back: second crc byte step, compare, pack, output register
    mscrc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .poly       (poly_reg),
        .q_stat     (q_stat),
        .head_entry (head_entry),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // an accepted item is waiting in the queue on the next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !q_stat.empty)
        else $error("accepted item missing from queue");

    // a built frame always carries the tail, and then no check fields
    a_build_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[47:32] == 16'h0000)
        else $error("build result with check fields set");

    // a check result carries no frame
    a_check_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[1] |-> m_tdata[31:0] == 32'h0000_0000 && m_tdata[47:42] == 6'd0)
        else $error("check result with frame bits set");

endmodule

`default_nettype wire
